>>> sv/ezq_pkg.sv
// ----------------------------------------------------------------------------
// ezq_pkg: shared constants for the Euler ZYX to quaternion converter
// Formats, CORDIC working width, angle limits and the arctangent table.
// ----------------------------------------------------------------------------
package ezq_pkg;

    // Field formats.
    localparam int ANGLE_WIDTH   = 16;
    localparam int QUAT_WIDTH    = 16;
    localparam int CORDIC_STAGES = 16;

    // Working precision of the CORDIC and product datapath.
    localparam int WORK_FRAC  = 30;
    localparam int WORK_WIDTH = 34;
    localparam int PROD_WIDTH = 2 * WORK_WIDTH;

    // Angle format Q3.F and the shift that gives the half angle at 2^-30.
    localparam int ANGLE_FRAC = ANGLE_WIDTH - 3;
    localparam int HALF_SHIFT = 29 - ANGLE_FRAC;

    // Pi at 2^-60, and pi rounded to the angle format.
    localparam logic [63:0] PI_2P60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] PI_ANGLE_U =
        (PI_2P60 + (64'd1 << (59 - ANGLE_FRAC))) >> (60 - ANGLE_FRAC);
    localparam logic signed [ANGLE_WIDTH-1:0] PI_ANGLE = ANGLE_WIDTH'(PI_ANGLE_U);

    // CORDIC start value: the reciprocal of the limit gain at 2^-30.
    localparam logic signed [WORK_WIDTH-1:0] CORDIC_GAIN = WORK_WIDTH'(652032874);

    // Output rounding shift and saturation bounds.
    localparam int OUT_SHIFT = 2 * WORK_FRAC - (QUAT_WIDTH - 1);
    localparam logic signed [PROD_WIDTH-1:0] QUAT_MAX =
        (PROD_WIDTH'(1) <<< (QUAT_WIDTH - 1)) - PROD_WIDTH'(1);
    localparam logic signed [PROD_WIDTH-1:0] QUAT_MIN = -(PROD_WIDTH'(1) <<< (QUAT_WIDTH - 1));

    // Arctangent of 2^-i at 2^-30; beyond the table it equals 2^(30-i).
    function automatic logic signed [WORK_WIDTH-1:0] atan_entry(input int idx);
        logic signed [WORK_WIDTH-1:0] val;
        case (idx)
            0:       val = WORK_WIDTH'(843314857);
            1:       val = WORK_WIDTH'(497837829);
            2:       val = WORK_WIDTH'(263043837);
            3:       val = WORK_WIDTH'(133525159);
            4:       val = WORK_WIDTH'(67021687);
            5:       val = WORK_WIDTH'(33543516);
            6:       val = WORK_WIDTH'(16775851);
            7:       val = WORK_WIDTH'(8388437);
            8:       val = WORK_WIDTH'(4194283);
            9:       val = WORK_WIDTH'(2097149);
            default: val = (idx <= 30) ? (WORK_WIDTH'(1) <<< (30 - idx)) : '0;
        endcase
        return val;
    endfunction

endpackage

>>> sv/ezq_lane.sv
// ----------------------------------------------------------------------------
// ezq_lane: pipelined CORDIC lane for one angle
// Clamps the angle to plus or minus pi, halves it and rotates through one
// registered stage per CORDIC iteration to give the half-angle cosine and sine.
// ----------------------------------------------------------------------------
module ezq_lane (
    input  logic                                    i_clk,
    input  logic signed [ezq_pkg::ANGLE_WIDTH-1:0]  i_angle,
    output logic signed [ezq_pkg::WORK_WIDTH-1:0]   o_cos,
    output logic signed [ezq_pkg::WORK_WIDTH-1:0]   o_sin
);
    import ezq_pkg::*;

    logic signed [WORK_WIDTH-1:0] r_x [0:CORDIC_STAGES];
    logic signed [WORK_WIDTH-1:0] r_y [0:CORDIC_STAGES];
    logic signed [WORK_WIDTH-1:0] r_z [0:CORDIC_STAGES];
    logic signed [ANGLE_WIDTH-1:0] n_clamped;

    // Clamp the angle to the nearer bound of plus or minus pi.
    always_comb begin
        if (i_angle > PI_ANGLE) begin
            n_clamped = PI_ANGLE;
        end else if (i_angle < -PI_ANGLE) begin
            n_clamped = -PI_ANGLE;
        end else begin
            n_clamped = i_angle;
        end
    end

    // Entry stage: half angle at 2^-30, vector at the reciprocal gain on the x axis.
    always_ff @(posedge i_clk) begin
        r_x[0] <= CORDIC_GAIN;
        r_y[0] <= '0;
        r_z[0] <= WORK_WIDTH'(n_clamped) <<< HALF_SHIFT;
    end

    // One rotation per stage, direction taken from the residual angle.
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (r_z[k] >= 0) begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - atan_entry(k);
            end else begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + atan_entry(k);
            end
        end
    end

    assign o_cos = r_x[CORDIC_STAGES];
    assign o_sin = r_y[CORDIC_STAGES];

endmodule

>>> sv/ezq_merge.sv
// ----------------------------------------------------------------------------
// ezq_merge: quaternion product stage
// Combines the three lanes' cosines and sines into w, x, y and z through
// three registered steps: pair products, triple products, sum and saturate.
// ----------------------------------------------------------------------------
module ezq_merge (
    input  logic                                  i_clk,
    input  logic signed [ezq_pkg::WORK_WIDTH-1:0] i_c1,
    input  logic signed [ezq_pkg::WORK_WIDTH-1:0] i_s1,
    input  logic signed [ezq_pkg::WORK_WIDTH-1:0] i_c2,
    input  logic signed [ezq_pkg::WORK_WIDTH-1:0] i_s2,
    input  logic signed [ezq_pkg::WORK_WIDTH-1:0] i_c3,
    input  logic signed [ezq_pkg::WORK_WIDTH-1:0] i_s3,
    output logic signed [ezq_pkg::QUAT_WIDTH-1:0] o_quat_w,
    output logic signed [ezq_pkg::QUAT_WIDTH-1:0] o_quat_x,
    output logic signed [ezq_pkg::QUAT_WIDTH-1:0] o_quat_y,
    output logic signed [ezq_pkg::QUAT_WIDTH-1:0] o_quat_z
);
    import ezq_pkg::*;

    logic signed [WORK_WIDTH-1:0] r_cc, r_ss, r_sc, r_cs, r_c3, r_s3;
    logic signed [PROD_WIDTH-1:0] r_t0, r_t1, r_t2, r_t3, r_t4, r_t5, r_t6, r_t7;
    logic signed [QUAT_WIDTH-1:0] r_w, r_x, r_y, r_z;

    // Product of two 2^-30 values rounded back to 2^-30.
    function automatic logic signed [WORK_WIDTH-1:0] mul_rnd(
        input logic signed [WORK_WIDTH-1:0] a,
        input logic signed [WORK_WIDTH-1:0] b
    );
        logic signed [PROD_WIDTH-1:0] p;
        p = PROD_WIDTH'(a) * PROD_WIDTH'(b);
        p = (p + (PROD_WIDTH'(1) <<< (WORK_FRAC - 1))) >>> WORK_FRAC;
        return p[WORK_WIDTH-1:0];
    endfunction

    // Round half up to the output format and saturate.
    function automatic logic signed [QUAT_WIDTH-1:0] to_out(
        input logic signed [PROD_WIDTH-1:0] v
    );
        logic signed [PROD_WIDTH-1:0] r;
        r = (v + (PROD_WIDTH'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        if (r > QUAT_MAX) begin
            r = QUAT_MAX;
        end else if (r < QUAT_MIN) begin
            r = QUAT_MIN;
        end
        return r[QUAT_WIDTH-1:0];
    endfunction

    // Step one: roll and pitch pair products.
    always_ff @(posedge i_clk) begin
        r_cc <= mul_rnd(i_c1, i_c2);
        r_ss <= mul_rnd(i_s1, i_s2);
        r_sc <= mul_rnd(i_s1, i_c2);
        r_cs <= mul_rnd(i_c1, i_s2);
        r_c3 <= i_c3;
        r_s3 <= i_s3;
    end

    // Step two: exact triple products at 2^-60.
    always_ff @(posedge i_clk) begin
        r_t0 <= PROD_WIDTH'(r_cc) * PROD_WIDTH'(r_c3);
        r_t1 <= PROD_WIDTH'(r_ss) * PROD_WIDTH'(r_s3);
        r_t2 <= PROD_WIDTH'(r_sc) * PROD_WIDTH'(r_c3);
        r_t3 <= PROD_WIDTH'(r_cs) * PROD_WIDTH'(r_s3);
        r_t4 <= PROD_WIDTH'(r_cs) * PROD_WIDTH'(r_c3);
        r_t5 <= PROD_WIDTH'(r_sc) * PROD_WIDTH'(r_s3);
        r_t6 <= PROD_WIDTH'(r_cc) * PROD_WIDTH'(r_s3);
        r_t7 <= PROD_WIDTH'(r_ss) * PROD_WIDTH'(r_c3);
    end

    // Step three: combine terms, round and saturate.
    always_ff @(posedge i_clk) begin
        r_w <= to_out(r_t0 + r_t1);
        r_x <= to_out(r_t2 - r_t3);
        r_y <= to_out(r_t4 + r_t5);
        r_z <= to_out(r_t6 - r_t7);
    end

    assign o_quat_w = r_w;
    assign o_quat_x = r_x;
    assign o_quat_y = r_y;
    assign o_quat_z = r_z;

endmodule

>>> sv/euler_zyx_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_zyx_to_quaternion: ZYX Euler angles to unit quaternion
// Three CORDIC lanes give half-angle cosines and sines, a merge stage forms
// the saturated Q1.15 quaternion.
// ----------------------------------------------------------------------------
// The block is fully pipelined: busy stays low, so a request may be issued on
// every clock cycle. Each result appears on o_valid once its request has passed
// one clamp stage, one stage per CORDIC iteration in each lane, and three
// product stages. The receiver cannot stall; every result is on the ports for
// its one strobed cycle only.
module euler_zyx_to_quaternion (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [ezq_pkg::ANGLE_WIDTH-1:0] i_roll_angle,
    input  logic signed [ezq_pkg::ANGLE_WIDTH-1:0] i_pitch_angle,
    input  logic signed [ezq_pkg::ANGLE_WIDTH-1:0] i_yaw_angle,
    output logic                                  o_valid,
    output logic signed [ezq_pkg::QUAT_WIDTH-1:0]  o_quat_w,
    output logic signed [ezq_pkg::QUAT_WIDTH-1:0]  o_quat_x,
    output logic signed [ezq_pkg::QUAT_WIDTH-1:0]  o_quat_y,
    output logic signed [ezq_pkg::QUAT_WIDTH-1:0]  o_quat_z
);
    import ezq_pkg::*;

    localparam int LATENCY = CORDIC_STAGES + 4;

    logic signed [WORK_WIDTH-1:0] c1, s1, c2, s2, c3, s3;
    logic [LATENCY-1:0] r_vld;
    logic [LATENCY-1:0] n_vld;

    assign busy = 1'b0;

    // One lane per angle.
    ezq_lane u_roll  (.i_clk(i_clk), .i_angle(i_roll_angle),  .o_cos(c1), .o_sin(s1));
    ezq_lane u_pitch (.i_clk(i_clk), .i_angle(i_pitch_angle), .o_cos(c2), .o_sin(s2));
    ezq_lane u_yaw   (.i_clk(i_clk), .i_angle(i_yaw_angle),   .o_cos(c3), .o_sin(s3));

    // Merge the lanes into the quaternion.
    ezq_merge u_merge (
        .i_clk    (i_clk),
        .i_c1     (c1),
        .i_s1     (s1),
        .i_c2     (c2),
        .i_s2     (s2),
        .i_c3     (c3),
        .i_s3     (s3),
        .o_quat_w (o_quat_w),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z)
    );

    // Valid marks travel alongside the data.
    assign n_vld = {r_vld[LATENCY-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid = r_vld[LATENCY-1];

endmodule
